FILE: rtl/icv_pkg.sv
// Package for the 5x5 RGB image convolution block.
// Holds constants, register indexes, pixel, tap and job types.
// No dependencies.
`default_nettype none
package icv_pkg;
   localparam int MASK           = 5;
   localparam int RAD            = MASK / 2;
   localparam int LINES          = MASK - 1;
   localparam int NCH            = 3;
   localparam int SAMPLE_BITS    = 16;
   localparam int TAPS           = MASK * MASK;
   localparam int COEF_BITS      = 16;
   localparam int GROUP_TAPS     = 4;
   localparam int GROUPS         = 6;
   localparam int OUT_BITS       = 24;
   localparam int ROW_OUT_BITS   = 12;
   localparam int COL_OUT_BITS   = 10;
   localparam int WIDTH_BITS     = 11;
   localparam int MIN_WIDTH      = 3;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS + 1;
   localparam int ROWSUM_BITS    = PROD_BITS + 3;
   localparam int ACC_BITS       = ROWSUM_BITS + 2;
   localparam int FRAC_SHIFT     = 14;
   localparam int ROUND_HALF     = 1 << (FRAC_SHIFT - 1);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_IMAGE_WIDTH = 3'd0,
      REG_COEF_0      = 3'd1,
      REG_COEF_1      = 3'd2,
      REG_COEF_2      = 3'd3,
      REG_COEF_3      = 3'd4,
      REG_COEF_4      = 3'd5,
      REG_COEF_5      = 3'd6,
      REG_COEF_LAST   = 3'd7
   } csr_index_type;

   typedef logic [NCH-1:0][SAMPLE_BITS-1:0] pixel_type;
   typedef pixel_type [MASK-1:0] column_type;
   typedef pixel_type [LINES-1:0] line_entry_type;
   typedef logic [TAPS-1:0][COEF_BITS-1:0] taps_type;
   typedef logic [TAPS-1:0][SAMPLE_BITS-1:0] patch_type;

   typedef struct packed {
      logic [ROW_OUT_BITS-1:0] row;
      logic [COL_OUT_BITS-1:0] col;
      logic                    last_run;
      logic                    last_frame;
   } side_type;

   typedef struct packed {
      patch_type [NCH-1:0] patch;
      side_type            side;
   } job_type;

   typedef struct packed {
      logic prod;
      logic rows;
      logic total;
   } stage_en_type;
endpackage
`default_nettype wire

FILE: rtl/icv_req_if.sv
// Input pixel channel of the convolution block.
// Depends on icv_pkg for sample width.
`default_nettype none
interface icv_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [icv_pkg::SAMPLE_BITS-1:0] red_in;
   logic [icv_pkg::SAMPLE_BITS-1:0] green_in;
   logic [icv_pkg::SAMPLE_BITS-1:0] blue_in;
   modport source (output valid, operation, red_in, green_in, blue_in, input ready);
   modport sink (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/icv_rsp_if.sv
// Result channel of the convolution block.
// Depends on icv_pkg for field widths.
`default_nettype none
interface icv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [icv_pkg::OUT_BITS-1:0] red_out;
   logic signed [icv_pkg::OUT_BITS-1:0] green_out;
   logic signed [icv_pkg::OUT_BITS-1:0] blue_out;
   logic [icv_pkg::ROW_OUT_BITS-1:0]    out_row;
   logic [icv_pkg::COL_OUT_BITS-1:0]    out_col;
   logic                                last_of_run;
   logic                                last_of_frame;
   modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
                   last_of_run, last_of_frame, input ready);
   modport sink (input valid, red_out, green_out, blue_out, out_row, out_col,
                 last_of_run, last_of_frame, output ready);
endinterface
`default_nettype wire

FILE: rtl/icv_csr_if.sv
// Register write channel of the convolution block.
// Depends on icv_pkg for index and data widths.
`default_nettype none
interface icv_csr_if;
   logic                              valid;
   logic                              ready;
   logic [icv_pkg::CSR_ADDR_BITS-1:0] index;
   logic [icv_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/image_conv_5x5_rgb.sv
// Top level of the 5x5 RGB convolution: registers, window front end,
// three color lanes and the merging output stage.
// Depends on icv_pkg, the three channel interfaces, icv_window and icv_lane.
//
// Channel   Dir  Handshake     Word
// req_bus   in   valid/ready   operation, red_in, green_in, blue_in
// rsp_bus   out  valid/ready   red_out, green_out, blue_out, out_row, out_col, flags
// csr_bus   in   valid/ready   index, data (always ready)
//
// One pixel is taken per cycle while the window stage can take it; the last pixel of a row
// holds the input while the job stage issues the two right-border outputs.
// A result passes these registers after its pixel is taken: line store read,
// job stage, job register, products, row sums and total.
// Reset is synchronous and sets the valid flags, raster counters, width and coefficients; the line store
// needs no clearing pass. A stalled result moves into a skid register, so a stall
// reaches the earlier stages only in the cycle after it.
`default_nettype none
module image_conv_5x5_rgb #(
   parameter int MAX_WIDTH  = icv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = icv_pkg::DEF_MAX_HEIGHT
) (
   input wire logic clock,
   input wire logic reset,
   icv_req_if.sink   req_bus,
   icv_rsp_if.source rsp_bus,
   icv_csr_if.sink   csr_bus
);
   logic [icv_pkg::WIDTH_BITS-1:0]                          width_ff;
   logic [icv_pkg::GROUPS-1:0][icv_pkg::CSR_DATA_BITS-1:0]  coef_ff;
   logic [icv_pkg::COEF_BITS-1:0]                           coef_last_ff;
   icv_pkg::taps_type taps;

   logic             job_valid;
   logic             job_ready;
   icv_pkg::job_type job;
   icv_pkg::job_type job_ff;
   logic             c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;
   icv_pkg::side_type side_d_ff, side_e_ff, side_f_ff;
   logic             en_c, en_d, en_e, en_f;
   icv_pkg::stage_en_type en;
   logic signed [icv_pkg::NCH-1:0][icv_pkg::OUT_BITS-1:0] results;
   logic             skid_valid_ff;
   logic signed [icv_pkg::NCH-1:0][icv_pkg::OUT_BITS-1:0] skid_res_ff;
   icv_pkg::side_type skid_side_ff;
   logic signed [icv_pkg::NCH-1:0][icv_pkg::OUT_BITS-1:0] out_res;
   icv_pkg::side_type out_side;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= icv_pkg::WIDTH_BITS'(icv_pkg::DEF_MAX_WIDTH);
         coef_ff      <= '0;
         coef_last_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (icv_pkg::csr_index_type'(csr_bus.index))
            icv_pkg::REG_IMAGE_WIDTH: width_ff <= csr_bus.data[icv_pkg::WIDTH_BITS-1:0];
            icv_pkg::REG_COEF_0:      coef_ff[0] <= csr_bus.data;
            icv_pkg::REG_COEF_1:      coef_ff[1] <= csr_bus.data;
            icv_pkg::REG_COEF_2:      coef_ff[2] <= csr_bus.data;
            icv_pkg::REG_COEF_3:      coef_ff[3] <= csr_bus.data;
            icv_pkg::REG_COEF_4:      coef_ff[4] <= csr_bus.data;
            icv_pkg::REG_COEF_5:      coef_ff[5] <= csr_bus.data;
            icv_pkg::REG_COEF_LAST:   coef_last_ff <= csr_bus.data[icv_pkg::COEF_BITS-1:0];
            default:                  coef_last_ff <= coef_last_ff;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < icv_pkg::TAPS - 1; k++) begin
         taps[k] = coef_ff[k / icv_pkg::GROUP_TAPS]
                          [(k % icv_pkg::GROUP_TAPS) * icv_pkg::COEF_BITS +: icv_pkg::COEF_BITS];
      end
      taps[icv_pkg::TAPS-1] = coef_last_ff;
   end

   icv_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .image_width (width_ff),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job)
   );

   always_comb begin
      en_f      = !f_valid_ff || !skid_valid_ff;
      en_e      = !e_valid_ff || en_f;
      en_d      = !d_valid_ff || en_e;
      en_c      = !c_valid_ff || en_d;
      job_ready = en_c;
      en.prod   = en_d;
      en.rows   = en_e;
      en.total  = en_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         e_valid_ff    <= 1'b0;
         f_valid_ff    <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en_c) c_valid_ff <= job_valid;
         if (en_d) d_valid_ff <= c_valid_ff;
         if (en_e) e_valid_ff <= d_valid_ff;
         if (en_f) f_valid_ff <= e_valid_ff;
         if (skid_valid_ff) begin
            if (rsp_bus.ready) skid_valid_ff <= 1'b0;
         end else if (f_valid_ff && !rsp_bus.ready) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) job_ff <= job;
      if (en_d) side_d_ff <= job_ff.side;
      if (en_e) side_e_ff <= side_d_ff;
      if (en_f) side_f_ff <= side_e_ff;
      if (!skid_valid_ff) begin
         skid_res_ff  <= results;
         skid_side_ff <= side_f_ff;
      end
   end

   for (genvar ch = 0; ch < icv_pkg::NCH; ch++) begin : g_lane
      icv_lane u_lane (
         .clock  (clock),
         .en     (en),
         .taps   (taps),
         .patch  (job_ff.patch[ch]),
         .result (results[ch])
      );
   end

   assign out_res  = skid_valid_ff ? skid_res_ff : results;
   assign out_side = skid_valid_ff ? skid_side_ff : side_f_ff;

   assign rsp_bus.valid         = f_valid_ff || skid_valid_ff;
   assign rsp_bus.red_out       = out_res[0];
   assign rsp_bus.green_out     = out_res[1];
   assign rsp_bus.blue_out      = out_res[2];
   assign rsp_bus.out_row       = out_side.row;
   assign rsp_bus.out_col       = out_side.col;
   assign rsp_bus.last_of_run   = out_side.last_run;
   assign rsp_bus.last_of_frame = out_side.last_frame;
endmodule
`default_nettype wire

FILE: rtl/icv_window.sv
// Raster counters, line store, window register and per-output job generator.
// Depends on icv_pkg and icv_req_if.
`default_nettype none
module icv_window #(
   parameter int MAX_WIDTH  = icv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = icv_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   icv_req_if.sink                               req_bus,
   input  wire logic [icv_pkg::WIDTH_BITS-1:0]   image_width,
   output logic                                  job_valid,
   input  wire logic                             job_ready,
   output icv_pkg::job_type                      job
);
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WB       = $clog2(MAX_WIDTH + 1);
   localparam int CW       = (WB > icv_pkg::WIDTH_BITS) ? WB : icv_pkg::WIDTH_BITS;
   localparam int ROW_BITS = $clog2(MAX_HEIGHT + icv_pkg::RAD + 1);
   localparam int PW       = COL_BITS + 3;
   localparam int RW       = ROW_BITS + 1;

   logic [CW-1:0]       w_cfg;
   logic [CW-1:0]       w_eff;
   logic [COL_BITS-1:0] last_col;
   logic [COL_BITS-1:0] cidx;
   logic                accept;
   logic                row_end;
   logic                frame_end;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                flush_ff, flush_in;

   logic                   a_valid_ff;
   icv_pkg::pixel_type     a_pix_ff;
   logic [COL_BITS-1:0]    a_cidx_ff;
   logic [COL_BITS-1:0]    a_last_ff;
   logic [ROW_BITS-1:0]    a_row_ff;
   logic                   a_row_end_ff;
   logic                   a_frame_end_ff;
   icv_pkg::line_entry_type rd_ff;
   icv_pkg::line_entry_type wr_data;
   icv_pkg::line_entry_type mem [MAX_WIDTH];

   icv_pkg::column_type                  new_col;
   icv_pkg::column_type [icv_pkg::MASK-1:0]  win_cur;
   icv_pkg::column_type [icv_pkg::LINES-1:0] window_ff, window_in;

   logic                                    b_valid_ff;
   icv_pkg::column_type [icv_pkg::MASK-1:0] b_win_ff;
   logic [1:0]                              b_phase_ff;
   logic                                    b_row_end_ff;
   logic                                    b_frame_end_ff;
   logic [COL_BITS-1:0]                     b_cidx_ff;
   logic [COL_BITS-1:0]                     b_last_ff;
   logic [ROW_BITS-1:0]                     b_row_ff;

   logic       b_row_ok;
   logic       emit;
   logic       b_last;
   logic       b_step;
   logic       b_free;
   logic       a_to_b;
   logic [PW-1:0] pos0;
   logic [icv_pkg::MASK-1:0] col_ok;
   logic [icv_pkg::MASK-1:0] row_ok;

   always_comb begin
      w_cfg = CW'(image_width);
      if (w_cfg < CW'(icv_pkg::MIN_WIDTH)) begin
         w_eff = CW'(icv_pkg::MIN_WIDTH);
      end else if (w_cfg > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      last_col  = COL_BITS'(w_eff - CW'(1));
      cidx      = (col_ff > last_col) ? last_col : col_ff;
      accept    = req_bus.valid && req_bus.ready;
      row_end   = (cidx == last_col);
      frame_end = row_end && req_bus.operation && flush_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      flush_in  = flush_ff;
      if (accept) begin
         if (row_end) begin
            col_in   = '0;
            flush_in = req_bus.operation && !flush_ff;
            if (frame_end) begin
               row_in = '0;
            end else if (row_ff < ROW_BITS'(MAX_HEIGHT + icv_pkg::RAD)) begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end else begin
            col_in = cidx + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         flush_ff   <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         flush_ff <= flush_in;
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (a_to_b) begin
            a_valid_ff <= 1'b0;
         end
         if (a_to_b) begin
            b_valid_ff <= 1'b1;
         end else if (b_step && b_last) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff          <= mem[cidx];
         a_pix_ff       <= req_bus.operation ? '0 :
                           {req_bus.blue_in, req_bus.green_in, req_bus.red_in};
         a_cidx_ff      <= cidx;
         a_last_ff      <= last_col;
         a_row_ff       <= row_ff;
         a_row_end_ff   <= row_end;
         a_frame_end_ff <= frame_end;
      end
      if (a_to_b) begin
         mem[a_cidx_ff] <= wr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < icv_pkg::LINES - 1; i++) begin
         wr_data[i] = rd_ff[i+1];
      end
      wr_data[icv_pkg::LINES-1] = a_pix_ff;
      for (int i = 0; i < icv_pkg::LINES; i++) begin
         new_col[i] = rd_ff[i];
      end
      new_col[icv_pkg::LINES] = a_pix_ff;
      for (int j = 0; j < icv_pkg::LINES; j++) begin
         win_cur[j] = window_ff[j];
      end
      win_cur[icv_pkg::LINES] = new_col;
      if (a_row_end_ff) begin
         window_in    = '0;
         window_in[0] = win_cur[3];
         window_in[1] = win_cur[4];
      end else begin
         for (int j = 0; j < icv_pkg::LINES; j++) begin
            window_in[j] = win_cur[j+1];
         end
      end
   end

   always_comb begin
      b_row_ok = (b_row_ff >= ROW_BITS'(icv_pkg::RAD));
      emit     = (b_phase_ff == 2'd0) ? (b_row_ok && (b_cidx_ff >= COL_BITS'(icv_pkg::RAD)))
                                      : b_row_ok;
      b_last   = (b_phase_ff == (b_row_end_ff ? 2'(icv_pkg::RAD) : 2'd0));
      b_step   = b_valid_ff && (!emit || job_ready);
      b_free   = !b_valid_ff || (b_step && b_last);
      a_to_b   = a_valid_ff && b_free;
      req_bus.ready = !a_valid_ff || a_to_b;
      pos0 = PW'(b_cidx_ff) + PW'(b_phase_ff) - PW'(icv_pkg::RAD);
      for (int j = 0; j < icv_pkg::MASK; j++) begin
         col_ok[j] = (PW'(b_cidx_ff) + PW'(b_phase_ff) + PW'(j) >= PW'(2 * icv_pkg::RAD)) &&
                     (PW'(b_cidx_ff) + PW'(b_phase_ff) + PW'(j) <=
                      PW'(b_last_ff) + PW'(2 * icv_pkg::RAD));
      end
      for (int i = 0; i < icv_pkg::MASK; i++) begin
         row_ok[i] = (RW'(b_row_ff) + RW'(i) >= RW'(2 * icv_pkg::RAD));
      end
      for (int ch = 0; ch < icv_pkg::NCH; ch++) begin
         for (int i = 0; i < icv_pkg::MASK; i++) begin
            for (int j = 0; j < icv_pkg::MASK; j++) begin
               job.patch[ch][i*icv_pkg::MASK+j] =
                  (row_ok[i] && col_ok[j]) ? b_win_ff[j][i][ch] : '0;
            end
         end
      end
      job.side.row        = icv_pkg::ROW_OUT_BITS'(b_row_ff - ROW_BITS'(icv_pkg::RAD));
      job.side.col        = icv_pkg::COL_OUT_BITS'(pos0);
      job.side.last_run   = b_last;
      job.side.last_frame = b_last && b_frame_end_ff;
      job_valid           = b_valid_ff && emit;
   end

   always_ff @(posedge clock) begin
      if (a_to_b) begin
         window_ff      <= window_in;
         b_win_ff       <= win_cur;
         b_phase_ff     <= 2'd0;
         b_row_end_ff   <= a_row_end_ff;
         b_frame_end_ff <= a_frame_end_ff;
         b_cidx_ff      <= a_cidx_ff;
         b_last_ff      <= a_last_ff;
         b_row_ff       <= a_row_ff;
      end else if (b_step && !b_last) begin
         b_phase_ff <= b_phase_ff + 2'd1;
         for (int j = 0; j < icv_pkg::MASK - 1; j++) begin
            b_win_ff[j] <= b_win_ff[j+1];
         end
         b_win_ff[icv_pkg::MASK-1] <= '0;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/icv_lane.sv
// One color lane: 25 tap products, row sums, total and rounding.
// Depends on icv_pkg.
`default_nettype none
module icv_lane (
   input  wire logic                              clock,
   input  wire icv_pkg::stage_en_type             en,
   input  wire icv_pkg::taps_type                 taps,
   input  wire icv_pkg::patch_type                patch,
   output logic signed [icv_pkg::OUT_BITS-1:0]    result
);
   localparam int PB = icv_pkg::PROD_BITS;
   localparam int RB = icv_pkg::ROWSUM_BITS;
   localparam int AB = icv_pkg::ACC_BITS;

   logic [icv_pkg::TAPS-1:0][PB-1:0] prod_ff, prod_in;
   logic [icv_pkg::MASK-1:0][RB-1:0] rows_ff, rows_in;
   logic signed [icv_pkg::OUT_BITS-1:0] result_ff;
   logic signed [AB-1:0] acc;
   logic signed [AB-1:0] rounded;

   always_comb begin
      for (int k = 0; k < icv_pkg::TAPS; k++) begin
         prod_in[k] = PB'($signed({{(PB - icv_pkg::COEF_BITS){taps[k][icv_pkg::COEF_BITS-1]}},
                                   taps[k]}) *
                          $signed({{(PB - icv_pkg::SAMPLE_BITS){1'b0}}, patch[k]}));
      end
      for (int i = 0; i < icv_pkg::MASK; i++) begin
         rows_in[i] = '0;
         for (int j = 0; j < icv_pkg::MASK; j++) begin
            rows_in[i] = rows_in[i] +
               {{(RB - PB){prod_ff[i*icv_pkg::MASK+j][PB-1]}}, prod_ff[i*icv_pkg::MASK+j]};
         end
      end
      acc = '0;
      for (int i = 0; i < icv_pkg::MASK; i++) begin
         acc = acc + $signed({{(AB - RB){rows_ff[i][RB-1]}}, rows_ff[i]});
      end
      rounded = acc + AB'(icv_pkg::ROUND_HALF);
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         prod_ff <= prod_in;
      end
      if (en.rows) begin
         rows_ff <= rows_in;
      end
      if (en.total) begin
         result_ff <= rounded[AB-1:icv_pkg::FRAC_SHIFT];
      end
   end

   assign result = result_ff;
endmodule
`default_nettype wire
